@@ hw/rtl/wdq_pkg.sv @@
// ----------------------------------------------------------------------------
// wdq_pkg
// Shared types, constants and helpers of the waypoint density quantizer.
// ----------------------------------------------------------------------------
package wdq_pkg;

  // field and datapath widths
  localparam int COORD_W   = 24;
  localparam int ACCUM_W   = 32;
  localparam int SPACING_W = 24;
  localparam int ROOT_W    = COORD_W + 1;
  localparam int RAD_W     = 2 * ROOT_W;

  // request opcodes
  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        mag_t;

  typedef struct packed {
    op_e    op;
    coord_t ref_x;
    coord_t ref_y;
    coord_t ref_z;
  } in_req_t;

  typedef struct packed {
    coord_t set_x;
    coord_t set_y;
    coord_t set_z;
    logic   committed;
  } out_res_t;

  // magnitude of a - b, both subtractions side by side
  function automatic mag_t abs_diff(coord_t a, coord_t b);
    logic [COORD_W:0] ab;
    logic [COORD_W:0] ba;
    ab = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    ba = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    return ab[COORD_W] ? ba[COORD_W-1:0] : ab[COORD_W-1:0];
  endfunction

  // height step to 1/16 cm: times 25, then shift right by 6
  function automatic mag_t scale_dz(mag_t d);
    logic [COORD_W+4:0] p;
    p = {1'b0, d, 4'b0000} + {2'b00, d, 3'b000} + {5'b00000, d};
    return COORD_W'(p >> 6);
  endfunction

endpackage

@@ hw/rtl/wdq_isqrt.sv @@
// ----------------------------------------------------------------------------
// wdq_isqrt
// Bit-serial restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module wdq_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wdq_pkg::RAD_W-1:0]  radicand_i,
  output logic                       done_o,
  output logic [wdq_pkg::ROOT_W-1:0] root_o
);
  import wdq_pkg::*;

  localparam int CntW = $clog2(ROOT_W);

  logic                busy_q, busy_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [RAD_W-1:0]    rad_q, rad_d;
  logic [ROOT_W:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [ROOT_W+2:0]   rem_t;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   diff;
  logic                ge;

  // one trial subtraction per cycle
  assign rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign diff  = rem_t - trial;
  assign ge    = (rem_t >= trial);

  // sequencing of the root bits
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(ROOT_W - 1);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      rem_d  = ge ? diff[ROOT_W:0] : rem_t[ROOT_W:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

endmodule

@@ hw/rtl/waypoint_density_quantizer_core.sv @@
// ----------------------------------------------------------------------------
// waypoint_density_quantizer_core
// Thins a 3D reference path into setpoints spaced by accumulated arc length.
// ----------------------------------------------------------------------------
// One request gives one result. A sample that needs a step length passes
// through these steps from acceptance to the next acceptance: the idle
// state in which the request is taken, the coordinate differences, the
// shared squaring multiplier, the bit-serial square root and the
// accumulator update. Restart requests, the first point after reset or a
// restart and all samples at zero spacing skip the arithmetic and go
// straight from the differences to the update. The input stalls while a
// request is in work; a finished result waits in the output register while
// the next request is taken.
module waypoint_density_quantizer_core #(
  parameter int AccumWidth = wdq_pkg::ACCUM_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wdq_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wdq_pkg::out_res_t             out_res_o,
  input  logic                          cfg_we_i,
  input  logic [wdq_pkg::SPACING_W-1:0] cfg_wdata_i
);
  import wdq_pkg::*;

  localparam int SumW = ((AccumWidth > ROOT_W) ? AccumWidth : ROOT_W) + 1;
  localparam logic [SumW-1:0] AccMax = SumW'({AccumWidth{1'b1}});

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIFF = 5'b00010,
    S_MUL  = 5'b00100,
    S_ROOT = 5'b01000,
    S_UPD  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  in_req_t               req_q;
  logic [SPACING_W-1:0]  spacing_q;
  coord_t                prev_x_q, prev_y_q, prev_z_q;
  coord_t                held_x_q, held_y_q, held_z_q;
  logic [AccumWidth-1:0] accum_q;
  logic                  have_prev_q;
  mag_t                  dx_q, dy_q, dz_q;
  logic [1:0]            mul_cnt_q;
  logic [2*COORD_W-1:0]  prod_q;
  logic [RAD_W-1:0]      sumsq_q;
  logic                  out_valid_q;
  out_res_t              out_res_q;

  logic                  in_acc;
  logic                  fast;
  logic                  out_load;
  mag_t                  mul_op;
  logic                  sqrt_start;
  logic                  sqrt_done;
  logic [RAD_W-1:0]      radicand;
  logic [ROOT_W-1:0]     root;
  logic [SumW-1:0]       sum;
  logic [AccumWidth-1:0] sat;
  logic                  reach;

  // request handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fast       = (req_q.op == OP_RESTART) || (spacing_q == '0) || !have_prev_q;
  assign out_load   = (state_q == S_UPD) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_DIFF;
      S_DIFF: state_d = fast ? S_UPD : S_MUL;
      S_MUL:  if (mul_cnt_q == 2'd3) state_d = S_ROOT;
      S_ROOT: if (sqrt_done) state_d = S_UPD;
      S_UPD:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mul_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      mul_cnt_q <= (state_q == S_MUL) ? mul_cnt_q + 2'd1 : 2'd0;
    end
  end

  // spacing register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= '0;
    end else if (cfg_we_i) begin
      spacing_q <= cfg_wdata_i;
    end
  end

  // request capture and coordinate differences
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
    if (state_q == S_DIFF) begin
      dx_q <= abs_diff(req_q.ref_x, prev_x_q);
      dy_q <= abs_diff(req_q.ref_y, prev_y_q);
      dz_q <= scale_dz(abs_diff(req_q.ref_z, prev_z_q));
    end
  end

  // shared squaring multiplier, product registered before the add
  always_comb begin
    unique case (mul_cnt_q)
      2'd0:    mul_op = dx_q;
      2'd1:    mul_op = dy_q;
      default: mul_op = dz_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_q  <= mul_op * mul_op;
      sumsq_q <= (mul_cnt_q == 2'd0) ? '0 : sumsq_q + RAD_W'(prod_q);
    end
  end

  assign radicand   = sumsq_q + RAD_W'(prod_q);
  assign sqrt_start = (state_q == S_MUL) && (mul_cnt_q == 2'd3);

  wdq_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // saturating arc accumulation
  assign sum   = SumW'(accum_q) + SumW'(root);
  assign sat   = (sum > AccMax) ? AccMax[AccumWidth-1:0] : sum[AccumWidth-1:0];
  assign reach = (sat >= AccumWidth'(spacing_q));

  // tracking state update, taken when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_z_q    <= '0;
      accum_q     <= '0;
      have_prev_q <= 1'b0;
    end else if (out_load) begin
      priority if (req_q.op == OP_RESTART) begin
        accum_q     <= '0;
        have_prev_q <= 1'b0;
      end else if (spacing_q == '0) begin
        held_x_q    <= req_q.ref_x;
        held_y_q    <= req_q.ref_y;
        held_z_q    <= req_q.ref_z;
        accum_q     <= '0;
        have_prev_q <= 1'b0;
      end else if (!have_prev_q) begin
        held_x_q    <= req_q.ref_x;
        held_y_q    <= req_q.ref_y;
        held_z_q    <= req_q.ref_z;
        prev_x_q    <= req_q.ref_x;
        prev_y_q    <= req_q.ref_y;
        prev_z_q    <= req_q.ref_z;
        accum_q     <= '0;
        have_prev_q <= 1'b1;
      end else begin
        prev_x_q <= req_q.ref_x;
        prev_y_q <= req_q.ref_y;
        prev_z_q <= req_q.ref_z;
        if (reach) begin
          held_x_q <= req_q.ref_x;
          held_y_q <= req_q.ref_y;
          held_z_q <= req_q.ref_z;
          accum_q  <= '0;
        end else begin
          accum_q  <= sat;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if ((req_q.op == OP_SAMPLE) && (fast ? (have_prev_q == 1'b0 || spacing_q == '0)
                                           : reach)) begin
        out_res_q.set_x     <= req_q.ref_x;
        out_res_q.set_y     <= req_q.ref_y;
        out_res_q.set_z     <= req_q.ref_z;
        out_res_q.committed <= 1'b1;
      end else begin
        out_res_q.set_x     <= held_x_q;
        out_res_q.set_y     <= held_y_q;
        out_res_q.set_z     <= held_z_q;
        out_res_q.committed <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // checks
  a_root_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == S_ROOT))
    else $error("square root finished outside its wait state");

  a_restart_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (req_q.op == OP_RESTART)) |=> !out_res_q.committed && !have_prev_q)
    else $error("restart request committed a setpoint");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (req_q.op == OP_SAMPLE) && (spacing_q == '0))
      |=> out_res_q.committed && !have_prev_q && (accum_q == '0))
    else $error("zero spacing sample not passed through");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_load) |=> $stable(out_res_q) || !$past(out_stall_i))
    else $error("pending result changed");

endmodule

@@ tb/waypoint_density_quantizer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_density_quantizer_core_tb
// Self-checking bench for the arc-length setpoint thinner. Requests are driven
// through the valid/stall handshake, and a scoreboard predicts the held
// setpoint and commit flag of every result. The run covers directed corner
// points and random path walks under several spacing settings and idle mixes.
// ----------------------------------------------------------------------------
module waypoint_density_quantizer_core_tb;
  import wdq_pkg::*;

  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     SETTLE_CYCLES = 48;
  localparam int     BLOCK_ITEMS   = 155;
  localparam coord_t COORD_MAX     = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN     = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [SPACING_W-1:0] SPACING_MAX = '1;

  // scoreboard: predicts held setpoint per request and checks results in order
  class setpoint_scoreboard;
    out_res_t             setpoint_queue[$];
    logic [SPACING_W-1:0] spacing;
    coord_t               prev_x, prev_y, prev_z;
    coord_t               held_x, held_y, held_z;
    logic [ACCUM_W-1:0]   arc_accum;
    bit                   have_prev;
    int                   mismatches, requests, results, commits, restarts;

    function new();
      spacing   = '0;
      prev_x    = '0;
      prev_y    = '0;
      prev_z    = '0;
      held_x    = '0;
      held_y    = '0;
      held_z    = '0;
      arc_accum = '0;
      have_prev = 1'b0;
    endfunction

    function void set_spacing(logic [SPACING_W-1:0] v);
      spacing = v;
    endfunction

    function int pending();
      return setpoint_queue.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results);
      mismatches++;
    endtask

    function longint unsigned mag_diff(coord_t a, coord_t b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
    endfunction

    // floor of the euclidean length, bit by bit from the top
    function longint unsigned step_length(longint unsigned dx, longint unsigned dy,
                                          longint unsigned dz);
      longint unsigned radicand, root, trial;
      radicand = dx * dx + dy * dy + dz * dz;
      root = 0;
      for (int b = 26; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= radicand) root = trial;
      end
      return root;
    endfunction

    function void hold_point(in_req_t req);
      held_x = req.ref_x;
      held_y = req.ref_y;
      held_z = req.ref_z;
    endfunction

    function void note_request(in_req_t req);
      out_res_t        res;
      longint unsigned dz, len, total;
      requests++;
      res.committed = 1'b0;
      if (req.op == OP_RESTART) begin
        arc_accum = '0;
        have_prev = 1'b0;
        restarts++;
      end else if (spacing == 0) begin
        // pass-through: every sample lands, tracking cleared
        hold_point(req);
        have_prev     = 1'b0;
        arc_accum     = '0;
        res.committed = 1'b1;
      end else if (!have_prev) begin
        // first point after reset or restart lands at once
        hold_point(req);
        prev_x        = req.ref_x;
        prev_y        = req.ref_y;
        prev_z        = req.ref_z;
        arc_accum     = '0;
        have_prev     = 1'b1;
        res.committed = 1'b1;
      end else begin
        dz    = (mag_diff(req.ref_z, prev_z) * 25) >> 6;
        len   = step_length(mag_diff(req.ref_x, prev_x), mag_diff(req.ref_y, prev_y), dz);
        total = longint'(arc_accum) + len;
        arc_accum = (total > ((64'd1 << ACCUM_W) - 1)) ? '1 : total[ACCUM_W-1:0];
        prev_x = req.ref_x;
        prev_y = req.ref_y;
        prev_z = req.ref_z;
        if (arc_accum >= spacing) begin
          hold_point(req);
          arc_accum     = '0;
          res.committed = 1'b1;
        end
      end
      res.set_x = held_x;
      res.set_y = held_y;
      res.set_z = held_z;
      if (res.committed) commits++;
      setpoint_queue.push_back(res);
    endfunction

    task check_result(out_res_t got);
      out_res_t want;
      results++;
      if (setpoint_queue.size() == 0) begin
        report_mismatch("result with no request pending", 0, 0);
      end else begin
        want = setpoint_queue.pop_front();
        if (got.set_x !== want.set_x) report_mismatch("set_x", got.set_x, want.set_x);
        if (got.set_y !== want.set_y) report_mismatch("set_y", got.set_y, want.set_y);
        if (got.set_z !== want.set_z) report_mismatch("set_z", got.set_z, want.set_z);
        if (got.committed !== want.committed)
          report_mismatch("committed", got.committed, want.committed);
      end
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_req_t              in_req    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_res_t             out_res;
  logic                 cfg_we    = 1'b0;
  logic [SPACING_W-1:0] cfg_wdata = '0;

  setpoint_scoreboard book;
  int     send_idle_pct = 21;
  int     recv_idle_pct = 70;
  int     cycle_count   = 0;
  coord_t walk_x, walk_y, walk_z;

  waypoint_density_quantizer_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check accepted results, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_res);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic in_req_t make_req(op_e op, coord_t x, coord_t y, coord_t z);
    in_req_t req;
    req.op    = op;
    req.ref_x = x;
    req.ref_y = y;
    req.ref_z = z;
    return req;
  endfunction

  // one request: optional idle gap, then hold until accepted
  task automatic send_request(input in_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    book.note_request(req);
  endtask

  // hold off until every result is back and the block has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [SPACING_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.set_spacing(v);
  endtask

  function automatic coord_t walk_step();
    int r;
    r = $urandom_range(99);
    if (r < 70) return coord_t'(int'($urandom_range(64)) - 32);
    if (r < 95) return coord_t'(int'($urandom_range(8192)) - 4096);
    return coord_t'($urandom);
  endfunction

  // path walks with random content, some restarts and some wild points
  task automatic run_path_block(input int n);
    in_req_t req;
    int      pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        req = make_req(OP_RESTART, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      end else begin
        if (pick < 8) begin
          walk_x = coord_t'($urandom);
          walk_y = coord_t'($urandom);
          walk_z = coord_t'($urandom);
        end else begin
          walk_x = walk_x + walk_step();
          walk_y = walk_y + walk_step();
          walk_z = walk_z + walk_step();
        end
        req = make_req(OP_SAMPLE, walk_x, walk_y, walk_z);
      end
      send_request(req);
    end
  endtask

  initial begin
    book   = new();
    walk_x = '0;
    walk_y = '0;
    walk_z = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through at zero spacing, restart with junk coordinates
    write_spacing('0);
    send_request(make_req(OP_SAMPLE, '0, '0, '0));
    send_request(make_req(OP_SAMPLE, COORD_MAX, COORD_MIN, COORD_MAX));
    send_request(make_req(OP_SAMPLE, COORD_MIN, COORD_MAX, COORD_MIN));
    send_request(make_req(OP_RESTART, COORD_MAX, COORD_MAX, COORD_MIN));
    drain_results();

    // unit spacing: zero steps, one-unit steps, dz truncation
    write_spacing(24'd1);
    send_request(make_req(OP_SAMPLE, COORD_MIN, COORD_MIN, COORD_MIN));
    send_request(make_req(OP_SAMPLE, COORD_MAX, COORD_MAX, COORD_MAX));
    send_request(make_req(OP_SAMPLE, COORD_MAX, COORD_MAX, COORD_MAX));
    send_request(make_req(OP_SAMPLE, COORD_MAX - 24'sd1, COORD_MAX, COORD_MAX));
    send_request(make_req(OP_RESTART, '0, '0, '0));
    send_request(make_req(OP_SAMPLE, 24'sd5, 24'sd5, 24'sd5));
    send_request(make_req(OP_SAMPLE, 24'sd5, 24'sd5, 24'sd7));
    send_request(make_req(OP_SAMPLE, 24'sd5, 24'sd5, 24'sd10));
    send_request(make_req(OP_SAMPLE, 24'sd5, 24'sd5, -24'sd3));
    drain_results();

    // widest spacing with full-range steps
    write_spacing(SPACING_MAX);
    send_request(make_req(OP_SAMPLE, '0, '0, '0));
    send_request(make_req(OP_SAMPLE, COORD_MAX, COORD_MAX, COORD_MAX));
    send_request(make_req(OP_SAMPLE, COORD_MIN, COORD_MIN, COORD_MIN));
    send_request(make_req(OP_SAMPLE, COORD_MIN, COORD_MIN, COORD_MIN));

    // random walks, one spacing setting per block
    for (int blk = 0; blk < 6; blk++) begin
      drain_results();
      if (blk == 2) begin
        send_idle_pct = 70;
        recv_idle_pct = 21;
      end else if (blk == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (blk)
        0: write_spacing(24'd1);
        1: write_spacing(SPACING_W'($urandom_range(4000, 1)));
        2: write_spacing('0);
        3: write_spacing(SPACING_MAX);
        4: write_spacing(SPACING_W'($urandom_range(200000, 1)));
        default: write_spacing(SPACING_W'($urandom));
      endcase
      run_path_block(BLOCK_ITEMS);
    end

    drain_results();
    if (book.pending() != 0) book.report_mismatch("results never returned", 0, book.pending());
    $display("covered %0d requests (%0d restarts) over six random spacing blocks,",
             book.requests, book.restarts);
    $display("checked %0d results with %0d setpoint commits", book.results, book.commits);
    if (book.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
